// ----- src/enta_pkg.sv -----
// shared constants, types and the arctangent table for the ellipse angle block
package enta_pkg;

  localparam int COORD_BITS    = 16;
  localparam int COEF_BITS     = 32;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 18;

  // offset, product and gradient widths are exact for any register values
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + COEF_BITS;
  localparam int GRAD_BITS   = PROD_BITS + 1;
  // headroom for the half-turn flip and the cordic gain
  localparam int CORDIC_BITS = GRAD_BITS + 2;

  localparam int ZBITS         = 32;
  localparam int ATAN_LEN      = 40;
  localparam int ATAN_IDX_BITS = $clog2(ATAN_LEN);
  localparam int ROUND_SHIFT   = ZBITS - ANGLE_BITS;
  localparam logic [ZBITS:0] ROUND_INC =
    (ROUND_SHIFT > 0) ? ((ZBITS + 1)'(1) << (ROUND_SHIFT - 1)) : '0;
  localparam logic [ZBITS-1:0] HALF_TURN = ZBITS'(1) << (ZBITS - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int REG_COUNT    = 5;
  localparam int REG_IDX_BITS = $clog2(REG_COUNT);
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;
  localparam int DATA_BITS    = 32;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_COEF_XX  = 3'd2,
    REG_COEF_YY  = 3'd3,
    REG_COEF_XY  = 3'd4
  } enta_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COEF_BITS-1:0]  coef_xx;
    logic [COEF_BITS-1:0]  coef_yy;
    logic [COEF_BITS-1:0]  coef_xy;
  } enta_cfg_t;

  // direction vector handed from the front end to the cordic, two's complement
  typedef struct packed {
    logic [GRAD_BITS-1:0] vx;
    logic [GRAD_BITS-1:0] vy;
    logic                 zero;
    logic                 degen;
  } enta_vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } enta_qstat_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [ZBITS-1:0] atan_lut(input logic [ATAN_IDX_BITS-1:0] idx);
    logic [ZBITS-1:0] val;
    unique case (idx)
      6'd0:  val = 32'd536870912;
      6'd1:  val = 32'd316933406;
      6'd2:  val = 32'd167458907;
      6'd3:  val = 32'd85004756;
      6'd4:  val = 32'd42667331;
      6'd5:  val = 32'd21354465;
      6'd6:  val = 32'd10679838;
      6'd7:  val = 32'd5340245;
      6'd8:  val = 32'd2670163;
      6'd9:  val = 32'd1335087;
      6'd10: val = 32'd667544;
      6'd11: val = 32'd333772;
      6'd12: val = 32'd166886;
      6'd13: val = 32'd83443;
      6'd14: val = 32'd41722;
      6'd15: val = 32'd20861;
      6'd16: val = 32'd10430;
      6'd17: val = 32'd5215;
      6'd18: val = 32'd2608;
      6'd19: val = 32'd1304;
      6'd20: val = 32'd652;
      6'd21: val = 32'd326;
      6'd22: val = 32'd163;
      6'd23: val = 32'd81;
      6'd24: val = 32'd41;
      6'd25: val = 32'd20;
      6'd26: val = 32'd10;
      6'd27: val = 32'd5;
      6'd28: val = 32'd3;
      6'd29: val = 32'd1;
      6'd30: val = 32'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/enta_cfg.sv -----
// configuration register file behind the apb-style port
module enta_cfg import enta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output enta_cfg_t            cfg
);

  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr;

  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.coef_xx  <= COEF_BITS'(1);
      cfg.coef_yy  <= COEF_BITS'(1);
      cfg.coef_xy  <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_CENTER_X: cfg.center_x <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: cfg.center_y <= pwdata[COORD_BITS-1:0];
        REG_COEF_XX:  cfg.coef_xx  <= pwdata[COEF_BITS-1:0];
        REG_COEF_YY:  cfg.coef_yy  <= pwdata[COEF_BITS-1:0];
        REG_COEF_XY:  cfg.coef_xy  <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = DATA_BITS'(cfg.center_x);
      REG_CENTER_Y: prdata = DATA_BITS'(cfg.center_y);
      REG_COEF_XX:  prdata = DATA_BITS'(cfg.coef_xx);
      REG_COEF_YY:  prdata = DATA_BITS'(cfg.coef_yy);
      REG_COEF_XY:  prdata = DATA_BITS'(cfg.coef_xy);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- src/enta_front.sv -----
// front end: offset, gradient, mode select, zero and determinant flags
module enta_front import enta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  enta_cfg_t             cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [COORD_BITS-1:0] in_px,
  input  logic [COORD_BITS-1:0] in_py,
  output logic                  out_valid,
  input  logic                  out_ready,
  output enta_vec_t             out_vec
);

  logic ce;
  logic v1, v2, v3, v4;

  logic                        mode1, mode2, mode3;
  logic signed [DIFF_BITS-1:0] dx1, dy1;
  logic signed [PROD_BITS-1:0] p_ax, p_cy, p_cx, p_by;
  logic signed [GRAD_BITS-1:0] gx3, gy3;
  logic signed [GRAD_BITS-1:0] vx4, vy4;
  logic                        zero4, degen4;

  logic signed [2*COEF_BITS-1:0] ab, cc;
  logic                          degen;

  // all four stages move together whenever the last one can drain
  assign ce        = !v4 || out_ready;
  assign in_ready  = ce;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mode1 <= in_mode;
      dx1   <= DIFF_BITS'($signed(in_px)) - DIFF_BITS'($signed(cfg.center_x));
      dy1   <= DIFF_BITS'($signed(in_py)) - DIFF_BITS'($signed(cfg.center_y));

      mode2 <= mode1;
      p_ax  <= PROD_BITS'($signed(cfg.coef_xx)) * PROD_BITS'(dx1);
      p_cy  <= PROD_BITS'($signed(cfg.coef_xy)) * PROD_BITS'(dy1);
      p_cx  <= PROD_BITS'($signed(cfg.coef_xy)) * PROD_BITS'(dx1);
      p_by  <= PROD_BITS'($signed(cfg.coef_yy)) * PROD_BITS'(dy1);

      mode3 <= mode2;
      gx3   <= GRAD_BITS'(p_ax) + GRAD_BITS'(p_cy);
      gy3   <= GRAD_BITS'(p_cx) + GRAD_BITS'(p_by);

      // tangent is the gradient turned a quarter turn counter-clockwise
      vx4    <= mode3 ? -gy3 : gx3;
      vy4    <= mode3 ? gx3 : gy3;
      zero4  <= (gx3 == '0) && (gy3 == '0);
      degen4 <= degen;
    end
  end

  // user must write registers only while idle (unenforced); this settles in time
  always_ff @(posedge clk) begin
    ab    <= (2*COEF_BITS)'($signed(cfg.coef_xx)) * (2*COEF_BITS)'($signed(cfg.coef_yy));
    cc    <= (2*COEF_BITS)'($signed(cfg.coef_xy)) * (2*COEF_BITS)'($signed(cfg.coef_xy));
    degen <= !(ab > cc);
  end

  assign out_vec = '{vx: vx4, vy: vy4, zero: zero4, degen: degen4};

endmodule

// ----- src/enta_queue.sv -----
// short fifo between front end and cordic
module enta_queue import enta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  enta_vec_t   push_vec,
  input  logic        pop,
  output enta_vec_t   pop_vec,
  output enta_qstat_t stat
);

  enta_vec_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]  count, count_next;

  assign stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_vec    = mem[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + QCNT_BITS'(1);
      2'b01:   count_next = count - QCNT_BITS'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_vec;
    end
  end

endmodule

// ----- src/enta_cordic.sv -----
// back end: pipelined vectoring cordic, rounding and output register
module enta_cordic import enta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  enta_vec_t             in_vec,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_BITS-1:0] angle,
  output logic                  zero_direction,
  output logic                  degenerate
);

  logic ce;

  logic signed [GRAD_BITS-1:0]   vx_in, vy_in;
  logic signed [CORDIC_BITS-1:0] xs [CORDIC_STAGES+1];
  logic signed [CORDIC_BITS-1:0] ys [CORDIC_STAGES+1];
  logic [ZBITS-1:0]              zs [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]        vs, zf, dg;

  logic [ZBITS:0]            zsum;
  logic [ANGLE_BITS-1:0]     rounded;

  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;
  assign vx_in    = $signed(in_vec.vx);
  assign vy_in    = $signed(in_vec.vy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (ce) begin
      vs <= {vs[CORDIC_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zf <= {zf[CORDIC_STAGES-1:0], in_vec.zero};
      dg <= {dg[CORDIC_STAGES-1:0], in_vec.degen};
    end
  end

  // left half-plane vectors are flipped by a half turn first
  always_ff @(posedge clk) begin
    if (ce) begin
      if (vx_in < 0) begin
        xs[0] <= -CORDIC_BITS'(vx_in);
        ys[0] <= -CORDIC_BITS'(vy_in);
        zs[0] <= HALF_TURN;
      end else begin
        xs[0] <= CORDIC_BITS'(vx_in);
        ys[0] <= CORDIC_BITS'(vy_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (ce) begin
        if (ys[k] > 0) begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + atan_lut(ATAN_IDX_BITS'(k));
        end else begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - atan_lut(ATAN_IDX_BITS'(k));
        end
      end
    end
  end

  // round half up, then wrap to one turn
  assign zsum    = {1'b0, zs[CORDIC_STAGES]} + ROUND_INC;
  assign rounded = zsum[ZBITS-1:ROUND_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vs[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle          <= zf[CORDIC_STAGES] ? '0 : rounded;
      zero_direction <= zf[CORDIC_STAGES];
      degenerate     <= dg[CORDIC_STAGES];
    end
  end

endmodule

// ----- src/ellipse_normal_tangent_angle.sv -----
// ellipse normal or tangent angle: point stream in, binary angle stream out
// throughput: one word per cycle unless m_tready holds the output; the four-stage
// gradient front end, a 4-entry queue and the 18-stage cordic pipeline each advance
// one word per clock when not stalled by back-pressure
// reset: synchronous rst clears all valid state and the queue, and loads the
// registers with center 0, coef_xx = coef_yy = 1, coef_xy = 0
module ellipse_normal_tangent_angle import enta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // point_x [15:0], point_y [31:16]
  input  logic                 s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // angle [15:0]
  output logic [1:0]           m_tuser,   // zero_direction [0], degenerate [1]
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  enta_cfg_t   cfg;
  enta_vec_t   f_vec, q_vec;
  enta_qstat_t q_stat;
  logic        f_valid, f_ready, push;
  logic        b_ready, pop;
  logic        zero_direction, degenerate;

  assign pready = 1'b1;

  enta_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  enta_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_px     (s_tdata[COORD_BITS-1:0]),
    .in_py     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_vec   (f_vec)
  );

  assign f_ready = !q_stat.full;
  assign push    = f_valid && f_ready;
  assign pop     = !q_stat.empty && b_ready;

  enta_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_vec (f_vec),
    .pop      (pop),
    .pop_vec  (q_vec),
    .stat     (q_stat)
  );

  enta_cordic u_cordic (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (!q_stat.empty),
    .in_ready       (b_ready),
    .in_vec         (q_vec),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .angle          (m_tdata),
    .zero_direction (zero_direction),
    .degenerate     (degenerate)
  );

  assign m_tuser = {degenerate, zero_direction};

  // a zero direction always reports angle 0
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero direction with nonzero angle");

  // the input side only stalls when the queue is full
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_stat.full)
    else $error("input stalled while queue has room");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

// ----- verif/tb_ellipse_normal_tangent_angle.sv -----
// testbench for the ellipse normal and tangent angle block, checked word by word against a predictor
module tb_ellipse_normal_tangent_angle;
  import enta_pkg::*;

  typedef struct packed {
    logic [15:0] angle;
    logic        zero;
    logic        degen;
  } angle_word_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] px;
    logic [15:0] py;
    logic        given;
    angle_word_t word;
  } probe_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata  = '0;   // point_x [15:0], point_y [31:16]
  logic                 s_tuser  = 1'b0; // mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;         // angle [15:0]
  logic [1:0]           m_tuser;         // zero_direction [0], degenerate [1]
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_BITS-1:0] paddr    = '0;
  logic [DATA_BITS-1:0] pwdata   = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  ellipse_normal_tangent_angle dut (.*);

  // ellipse registers as the block should hold them
  logic signed [15:0] ctr_x = '0;
  logic signed [15:0] ctr_y = '0;
  logic signed [31:0] k_xx  = 32'sd1;
  logic signed [31:0] k_yy  = 32'sd1;
  logic signed [31:0] k_xy  = '0;

  // atan(2^-i), 2^32 units per turn
  logic [31:0] atan_turns [0:CORDIC_STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215
  };

  probe_t probes [0:19] = '{
    '{1'b0, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{1'b1, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{1'b0, 16'h7fff, 16'h0000, 1'b0, '0},
    '{1'b1, 16'h7fff, 16'h0000, 1'b0, '0},
    '{1'b0, 16'h8000, 16'h0000, 1'b0, '0},
    '{1'b1, 16'h8000, 16'h0000, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h7fff, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h8000, 1'b0, '0},
    '{1'b1, 16'h0000, 16'h8000, 1'b0, '0},
    '{1'b0, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{1'b0, 16'h8000, 16'h8000, 1'b0, '0},
    '{1'b1, 16'h8000, 16'h7fff, 1'b0, '0},
    '{1'b0, 16'h7fff, 16'h8000, 1'b0, '0},
    '{1'b0, 16'h0001, 16'h0000, 1'b0, '0},
    '{1'b0, 16'hffff, 16'h0000, 1'b0, '0},
    '{1'b0, 16'h0000, 16'h0001, 1'b0, '0},
    '{1'b0, 16'h0000, 16'hffff, 1'b0, '0},
    '{1'b1, 16'hffff, 16'hffff, 1'b0, '0},
    '{1'b0, 16'h0001, 16'h0001, 1'b0, '0},
    '{1'b1, 16'h5555, 16'haaaa, 1'b0, '0}
  };

  angle_word_t expected_angles [$];
  int          fault_count = 0;
  bit          source_gaps = 1'b1;
  bit          sink_gaps   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic angle_word_t predict_angle(input logic mode, input logic signed [15:0] px,
                                                input logic signed [15:0] py);
    longint      dx, dy, gx, gy, x, y, xs, ys;
    logic [31:0] z;
    logic [32:0] zr;
    angle_word_t r;
    int          i;
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    gx = longint'(k_xx) * dx + longint'(k_xy) * dy;
    gy = longint'(k_xy) * dx + longint'(k_yy) * dy;
    r.degen = !(longint'(k_xx) * longint'(k_yy) > longint'(k_xy) * longint'(k_xy));
    // tangent is the gradient turned a quarter turn counter-clockwise
    if (mode) begin
      x = -gy;
      y = gx;
    end else begin
      x = gx;
      y = gy;
    end
    r.zero  = (x == 0) && (y == 0);
    r.angle = '0;
    if (!r.zero) begin
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys;
          y -= xs;
          z += atan_turns[i];
        end else begin
          x -= ys;
          y += xs;
          z -= atan_turns[i];
        end
      end
      zr = {1'b0, z} + 33'h0000_8000;
      r.angle = zr[31:16];
    end
    return r;
  endfunction

  function automatic logic [15:0] rail_coord();
    logic [15:0] v;
    case ($urandom_range(4))
      0:       v = 16'h8000;
      1:       v = 16'hffff;
      2:       v = 16'h0000;
      3:       v = 16'h0001;
      default: v = 16'h7fff;
    endcase
    return v;
  endfunction

  // leaves the bus in its access phase; the caller idles it once the batch is done
  task automatic apb_write(input int unsigned idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CENTER_X: ctr_x = val[15:0];
      REG_CENTER_Y: ctr_y = val[15:0];
      REG_COEF_XX:  k_xx  = val;
      REG_COEF_YY:  k_yy  = val;
      REG_COEF_XY:  k_xy  = val;
      default: ;
    endcase
  endtask

  task automatic check_registers();
    logic [31:0] want;
    for (int i = 0; i < REG_COUNT; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_BITS'(i * 4);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (i)
        REG_CENTER_X: want = {16'h0000, ctr_x};
        REG_CENTER_Y: want = {16'h0000, ctr_y};
        REG_COEF_XX:  want = k_xx;
        REG_COEF_YY:  want = k_yy;
        default:      want = k_xy;
      endcase
      if (i == REG_CENTER_X || i == REG_CENTER_Y) begin
        if (prdata[15:0] !== want[15:0]) begin
          $display("%0t: register %0d expected %h got %h", $time, i, want[15:0], prdata[15:0]);
          fault_count++;
        end
      end else if (prdata !== want) begin
        $display("%0t: register %0d expected %h got %h", $time, i, want, prdata);
        fault_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_ellipse(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    // junk in the upper half of the center words must be dropped
    apb_write(REG_CENTER_X, {16'($urandom()), cx});
    apb_write(REG_CENTER_Y, {16'($urandom()), cy});
    apb_write(REG_COEF_XX, a);
    apb_write(REG_COEF_YY, b);
    apb_write(REG_COEF_XY, c);
    // writes past the last register are ignored
    for (int i = REG_COUNT; i < (1 << REG_IDX_BITS); i++) apb_write(i, $urandom());
    check_registers();
  endtask

  task automatic send_word(input logic mode, input logic [15:0] px, input logic [15:0] py,
                           input logic given, input angle_word_t given_word);
    while (source_gaps && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
    expected_angles.push_back(given ? given_word : predict_angle(mode, px, py));
  endtask

  always @(posedge clk) begin
    m_tready <= !rst && (!sink_gaps || $urandom_range(99) >= 30);
  end

  always @(posedge clk) begin : result_check
    angle_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected word expected none got angle %h flags %b",
                 $time, m_tdata, m_tuser);
        fault_count++;
      end else begin
        want = expected_angles.pop_front();
        if (m_tdata !== want.angle) begin
          $display("%0t: angle expected %h got %h", $time, want.angle, m_tdata);
          fault_count++;
        end
        if (m_tuser[0] !== want.zero) begin
          $display("%0t: zero_direction expected %b got %b", $time, want.zero, m_tuser[0]);
          fault_count++;
        end
        if (m_tuser[1] !== want.degen) begin
          $display("%0t: degenerate expected %b got %b", $time, want.degen, m_tuser[1]);
          fault_count++;
        end
      end
    end
  end

  initial begin
    logic [15:0] px, py, cx, cy;
    logic [31:0] ka, kb, kc;
    int          sc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_registers();
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: ;
        // extremes: positive extremes on the diagonal, the cross term makes it degenerate
        1: load_ellipse(16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        // negative definite at full scale
        2: load_ellipse(16'h8000, 16'h7fff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        3: load_ellipse(16'd1600, -16'sd800, 32'd9, 32'd4, 32'd1);
        // zero determinant
        4: load_ellipse(16'($urandom()), 16'($urandom()), 32'd5, 32'd5, 32'd5);
        5: load_ellipse(16'($urandom()), 16'($urandom()), '0, '0, '0);
        default: begin
          cx = 16'($urandom());
          cy = 16'($urandom());
          case ($urandom_range(2))
            0: begin
              ka = $urandom_range(2000, 1);
              kb = $urandom_range(2000, 1);
              kc = 32'(int'($urandom_range(3000)) - 1500);
            end
            1: begin
              ka = $urandom();
              kb = $urandom();
              kc = $urandom();
            end
            default: begin
              sc = $urandom_range(20);
              ka = 32'($urandom_range(64, 1)) << sc;
              kb = 32'($urandom_range(64, 1)) << sc;
              kc = 32'((int'($urandom_range(64)) - 32) <<< sc);
            end
          endcase
          load_ellipse(cx, cy, ka, kb, kc);
        end
      endcase
      source_gaps = (phase != 3);
      sink_gaps   = (phase != 3);
      if (phase == 0) begin
        foreach (probes[i])
          send_word(probes[i].mode, probes[i].px, probes[i].py, probes[i].given, probes[i].word);
      end
      for (int n = 0; n < 112; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            px = 16'($urandom());
            py = 16'($urandom());
          end
          4, 5: begin
            px = ctr_x + 16'($urandom_range(16)) - 16'd8;
            py = ctr_y + 16'($urandom_range(16)) - 16'd8;
          end
          // on an axis through the center
          6: begin
            if ($urandom_range(1)) begin
              px = ctr_x;
              py = 16'($urandom());
            end else begin
              px = 16'($urandom());
              py = ctr_y;
            end
          end
          7: begin
            px = ctr_x;
            py = ctr_y;
          end
          8: begin
            px = rail_coord();
            py = rail_coord();
          end
          default: begin
            px = 16'($urandom_range(128)) - 16'd64;
            py = 16'($urandom_range(128)) - 16'd64;
          end
        endcase
        send_word(1'($urandom()), px, py, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
